FILE: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the go-back-N sender window
// Phase, packet kind and event codes, register indexes and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned WIN_CAP    = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;

  localparam int unsigned WIN_W      = 7;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(500000);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CONNECTING = 3'd1,
    PH_SENDING    = 3'd2,
    PH_CLOSING    = 3'd3,
    PH_DONE       = 3'd4,
    PH_FAILED     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_TICK  = 2'd1,
    OP_RX    = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RX_START = 2'd0,
    RX_END   = 2'd1,
    RX_DATA  = 2'd2,
    RX_ACK   = 2'd3
  } rx_type_t;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_TOTAL_PACKETS = 2'd1,
    REG_START_SEQ     = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // capture the event
    logic decode;   // apply the event to the window state
    logic advance;  // fill the window or close
    logic emit;     // load one result into the output register
  } gbn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_adv;  // decoded event moves the window
    logic out_free;  // output register can take a result
    logic emit_last; // result being loaded ends the event
  } gbn_sts_t;

endpackage

FILE: hw/rtl/gbn_if.sv
// ----------------------------------------------------------------------------
// gbn_if: event and result channels of the go-back-N sender window
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gbn_ev_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  rx_type;
  logic [31:0] rx_seq;

  modport source (output valid, output op, output rx_type, output rx_seq, input ready);
  modport sink   (input valid, input op, input rx_type, input rx_seq, output ready);
endinterface

interface gbn_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  pkt_kind;
  logic [31:0] pkt_seq;
  logic        last;
  logic [2:0]  phase_now;

  modport source (output valid, output pkt_kind, output pkt_seq, output last,
                  output phase_now, input ready);
  modport sink   (input valid, input pkt_kind, input pkt_seq, input last,
                  input phase_now, output ready);
endinterface

FILE: hw/rtl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core: go-back-N sliding-window sender controller
//
// Events (begin, tick, received packet) arrive on ev_in; for each event the
// block sends one or more results on res_out, each naming a packet to send
// (START, END, DATA or none) with its sequence number, the phase after the
// event, and last set on the event's final result.
// Registers (window size, packet count, START/END sequence, timeout) are
// written through cfg_we/cfg_idx/cfg_data; the user must write them only
// while the block is idle; the block does not enforce it. Timing: an event
// is taken and decoded in the next cycle; its first result enters the output
// register from the emit state, through the advance state for an ACK that
// moves the window. A burst runs at one result per cycle while res_out does
// not stall; the next event is taken once the final result is in the output
// register, while that result still waits. A retransmit burst is bounded by
// the window size. A stall on res_out holds the output register and the burst
// in place. Reset (synchronous) returns the phase to idle, clears base, next
// and the timer, and restores the registers to their reset values.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
  gbn_ev_if.sink                         ev_in,
  gbn_res_if.source                      res_out
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;

  // Sequencer
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_in.valid),
    .ev_ready (ev_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window state and output register
  gbn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .ev_op      (ev_in.op),
    .ev_rx_type (ev_in.rx_type),
    .ev_rx_seq  (ev_in.rx_seq),
    .cmd        (cmd),
    .sts        (sts),
    .res_ready  (res_out.ready),
    .res_valid  (res_out.valid),
    .res_kind   (res_out.pkt_kind),
    .res_seq    (res_out.pkt_seq),
    .res_last   (res_out.last),
    .res_phase  (res_out.phase_now)
  );

  // A taken event keeps the input closed in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    ev_in.valid && ev_in.ready |=> !ev_in.ready)
    else $error("event taken while the previous one is still in work");

  // A status-only result always ends its event
  assert property (@(posedge clk) disable iff (rst)
    res_out.valid && (res_out.pkt_kind == gbn_pkg::KIND_NONE) |-> res_out.last)
    else $error("status result not marked last");

  // START is only sent on entering the connecting phase
  assert property (@(posedge clk) disable iff (rst)
    res_out.valid && (res_out.pkt_kind == gbn_pkg::KIND_START) |->
      (res_out.phase_now == gbn_pkg::PH_CONNECTING) && res_out.last)
    else $error("START sent outside connecting phase");

  // DATA is only sent while the window is open
  assert property (@(posedge clk) disable iff (rst)
    res_out.valid && (res_out.pkt_kind == gbn_pkg::KIND_DATA) |->
      (res_out.phase_now == gbn_pkg::PH_SENDING))
    else $error("DATA sent outside sending phase");

endmodule

FILE: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: sequencer of the go-back-N sender window
// Steps each event through capture, decode, optional window advance and the
// emission of its results, one result per free output slot.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              ev_valid,
  output logic              ev_ready,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_ADVANCE,
    S_EMIT
  } state_t;

  state_t state;

  // Decode commands from the current state
  always_comb begin
    ev_ready    = (state == S_IDLE);
    cmd.accept  = (state == S_IDLE) && ev_valid;
    cmd.decode  = (state == S_DECODE);
    cmd.advance = (state == S_ADVANCE);
    cmd.emit    = (state == S_EMIT) && sts.out_free;
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ev_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          state <= sts.need_adv ? S_ADVANCE : S_EMIT;
        end
        S_ADVANCE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free && sts.emit_last) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp: datapath of the go-back-N sender window
// Holds the configuration, the window state and timer, the pending burst
// description and the output register.
// ----------------------------------------------------------------------------
module gbn_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       ev_op,
  input  logic [1:0]                       ev_rx_type,
  input  logic [gbn_pkg::SEQ_W-1:0]        ev_rx_seq,
  input  gbn_pkg::gbn_cmd_t                cmd,
  output gbn_pkg::gbn_sts_t                sts,
  input  logic                             res_ready,
  output logic                             res_valid,
  output logic [1:0]                       res_kind,
  output logic [gbn_pkg::SEQ_W-1:0]        res_seq,
  output logic                             res_last,
  output logic [2:0]                       res_phase
);

  typedef enum logic [1:0] {
    EM_NONE,
    EM_SINGLE,
    EM_RANGE
  } em_mode_t;

  // Configuration
  logic [gbn_pkg::WIN_W-1:0]  window_size;
  logic [gbn_pkg::SEQ_W-1:0]  total_packets;
  logic [gbn_pkg::SEQ_W-1:0]  start_seq;
  logic [gbn_pkg::TICK_W-1:0] timeout_ticks;

  // Window state
  gbn_pkg::phase_t            phase;
  logic [gbn_pkg::SEQ_W-1:0]  window_base;
  logic [gbn_pkg::SEQ_W-1:0]  next_to_send;
  logic [gbn_pkg::TICK_W-1:0] elapsed_ticks;

  // Captured event
  gbn_pkg::op_t               op_q;
  gbn_pkg::rx_type_t          rx_type_q;
  logic [gbn_pkg::SEQ_W-1:0]  rx_seq_q;

  // Pending burst
  em_mode_t                   em_mode;
  gbn_pkg::kind_t             em_kind;
  logic [gbn_pkg::SEQ_W-1:0]  em_cur;
  logic [gbn_pkg::SEQ_W-1:0]  em_hi;

  // Decode helpers
  logic [gbn_pkg::TICK_W-1:0] elapsed_inc;
  logic                       expired;
  logic                       is_ack;
  logic                       ack_fits;
  logic                       conn_ack;
  logic                       close_ack;

  // Advance helpers
  logic [gbn_pkg::WIN_W-1:0]  win_eff;
  logic [gbn_pkg::SEQ_W:0]    limit;
  logic [gbn_pkg::SEQ_W-1:0]  hi_val;
  logic                       base_done;

  // Emit helpers
  logic [gbn_pkg::SEQ_W:0]    cur_inc;
  logic                       range_has;
  gbn_pkg::kind_t             nx_kind;
  logic [gbn_pkg::SEQ_W-1:0]  nx_seq;
  logic                       nx_last;

  // Timer and ACK checks
  always_comb begin
    elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
    expired     = (elapsed_inc >= timeout_ticks);
    is_ack      = (op_q == gbn_pkg::OP_RX) && (rx_type_q == gbn_pkg::RX_ACK);
    ack_fits    = (rx_seq_q > window_base) && (rx_seq_q <= next_to_send);
    conn_ack    = is_ack && (phase == gbn_pkg::PH_CONNECTING) && (rx_seq_q == start_seq);
    close_ack   = is_ack && (phase == gbn_pkg::PH_CLOSING) && (rx_seq_q == start_seq);
  end

  // Window limit, clamped to the supported window
  always_comb begin
    if (window_size == '0) begin
      win_eff = gbn_pkg::WIN_W'(1);
    end else if (window_size > gbn_pkg::WIN_W'(gbn_pkg::WIN_CAP)) begin
      win_eff = gbn_pkg::WIN_W'(gbn_pkg::WIN_CAP);
    end else begin
      win_eff = window_size;
    end
    limit     = {1'b0, window_base} + (gbn_pkg::SEQ_W+1)'(win_eff);
    hi_val    = (limit < {1'b0, total_packets}) ? limit[gbn_pkg::SEQ_W-1:0] : total_packets;
    base_done = (window_base >= total_packets);
  end

  // Next result of the pending burst
  always_comb begin
    cur_inc   = {1'b0, em_cur} + 1'b1;
    range_has = (em_cur < em_hi);
    nx_kind   = gbn_pkg::KIND_NONE;
    nx_seq    = '0;
    nx_last   = 1'b1;
    unique case (em_mode)
      EM_SINGLE: begin
        nx_kind = em_kind;
        nx_seq  = em_cur;
      end
      EM_RANGE: begin
        if (range_has) begin
          nx_kind = gbn_pkg::KIND_DATA;
          nx_seq  = em_cur;
          nx_last = (cur_inc == {1'b0, em_hi});
        end
      end
      default: begin
        nx_kind = gbn_pkg::KIND_NONE;
      end
    endcase
  end

  always_comb begin
    sts.need_adv  = conn_ack || (is_ack && (phase == gbn_pkg::PH_SENDING) && ack_fits);
    sts.out_free  = !res_valid || res_ready;
    sts.emit_last = nx_last;
  end

  // Capture the event
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q      <= gbn_pkg::op_t'(ev_op);
      rx_type_q <= gbn_pkg::rx_type_t'(ev_rx_type);
      rx_seq_q  <= ev_rx_seq;
    end
  end

  // Configuration, window state, burst and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= gbn_pkg::WIN_W'(1);
      total_packets <= '0;
      start_seq     <= '0;
      timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
      phase         <= gbn_pkg::PH_IDLE;
      window_base   <= '0;
      next_to_send  <= '0;
      elapsed_ticks <= '0;
      em_mode       <= EM_NONE;
      em_kind       <= gbn_pkg::KIND_NONE;
      em_cur        <= '0;
      em_hi         <= '0;
      res_valid     <= 1'b0;
      res_kind      <= gbn_pkg::KIND_NONE;
      res_seq       <= '0;
      res_last      <= 1'b0;
      res_phase     <= gbn_pkg::PH_IDLE;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (gbn_pkg::cfg_reg_t'(cfg_idx))
          gbn_pkg::REG_WINDOW_SIZE:   window_size   <= cfg_data[gbn_pkg::WIN_W-1:0];
          gbn_pkg::REG_TOTAL_PACKETS: total_packets <= cfg_data[gbn_pkg::SEQ_W-1:0];
          gbn_pkg::REG_START_SEQ:     start_seq     <= cfg_data[gbn_pkg::SEQ_W-1:0];
          gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[gbn_pkg::TICK_W-1:0];
          default: ;
        endcase
      end

      // Apply the event
      if (cmd.decode) begin
        em_mode <= EM_NONE;
        priority if (op_q == gbn_pkg::OP_BEGIN) begin
          if (phase == gbn_pkg::PH_IDLE || phase == gbn_pkg::PH_DONE ||
              phase == gbn_pkg::PH_FAILED) begin
            window_base   <= '0;
            next_to_send  <= '0;
            elapsed_ticks <= '0;
            phase         <= gbn_pkg::PH_CONNECTING;
            em_mode       <= EM_SINGLE;
            em_kind       <= gbn_pkg::KIND_START;
            em_cur        <= start_seq;
          end
        end else if (op_q == gbn_pkg::OP_TICK) begin
          if (phase == gbn_pkg::PH_CONNECTING) begin
            elapsed_ticks <= elapsed_inc;
            if (expired) phase <= gbn_pkg::PH_FAILED;
          end else if (phase == gbn_pkg::PH_SENDING) begin
            if (expired) begin
              // resend everything outstanding
              elapsed_ticks <= '0;
              em_mode       <= EM_RANGE;
              em_cur        <= window_base;
              em_hi         <= next_to_send;
            end else begin
              elapsed_ticks <= elapsed_inc;
            end
          end else if (phase == gbn_pkg::PH_CLOSING) begin
            if (expired) begin
              elapsed_ticks <= '0;
              em_mode       <= EM_SINGLE;
              em_kind       <= gbn_pkg::KIND_END;
              em_cur        <= start_seq;
            end else begin
              elapsed_ticks <= elapsed_inc;
            end
          end
        end else if (conn_ack) begin
          phase         <= gbn_pkg::PH_SENDING;
          elapsed_ticks <= '0;
        end else if (sts.need_adv) begin
          window_base   <= rx_seq_q;
          elapsed_ticks <= '0;
        end else if (close_ack) begin
          phase <= gbn_pkg::PH_DONE;
        end
      end

      // Fill the window, or send END once all is acknowledged
      if (cmd.advance) begin
        if (base_done) begin
          phase         <= gbn_pkg::PH_CLOSING;
          elapsed_ticks <= '0;
          em_mode       <= EM_SINGLE;
          em_kind       <= gbn_pkg::KIND_END;
          em_cur        <= start_seq;
        end else begin
          em_mode <= EM_RANGE;
          em_cur  <= next_to_send;
          em_hi   <= hi_val;
          if (next_to_send < hi_val) next_to_send <= hi_val;
        end
      end

      // Output register: load on emit, drop after the transfer
      if (cmd.emit) begin
        res_valid <= 1'b1;
        res_kind  <= nx_kind;
        res_seq   <= nx_seq;
        res_last  <= nx_last;
        res_phase <= phase;
        em_cur    <= cur_inc[gbn_pkg::SEQ_W-1:0];
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
